/* rtl/uspc_pkg.sv */
// Package for the ultrasonic presence counter.
// Holds widths, constants and register indexes; depends on nothing.
`default_nettype none

package uspc_pkg;

    localparam int SAMPLES_PER_GROUP = 3;

    localparam int ECHO_W  = 16;
    localparam int CFG_W   = 10;
    localparam int MUL_W   = 11;
    localparam int PROD_W  = ECHO_W + MUL_W;
    localparam int FRAC_W  = 8;
    localparam int DIST_W  = PROD_W - FRAC_W;
    localparam int VDIST_W = CFG_W + FRAC_W;
    localparam int SUM_W   = VDIST_W + $clog2(SAMPLES_PER_GROUP);
    localparam int CNT_W   = ($clog2(SAMPLES_PER_GROUP + 1) > 2) ?
                             $clog2(SAMPLES_PER_GROUP + 1) : 2;
    localparam int IDX_W   = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;
    localparam int DIVC_W  = $clog2(SUM_W);
    localparam int COUNT_W = 16;
    localparam int AVG_W   = 19;
    localparam int VS_W    = 2;
    localparam int OUT_W   = AVG_W + VS_W + 3 + COUNT_W;
    localparam int IDX_CFG_W = 2;

    localparam logic [MUL_W-1:0]   DIST_MUL  = MUL_W'(1124);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [IDX_CFG_W-1:0] REG_WALL   = IDX_CFG_W'(0);
    localparam logic [IDX_CFG_W-1:0] REG_MARGIN = IDX_CFG_W'(1);
    localparam logic [IDX_CFG_W-1:0] REG_MIN    = IDX_CFG_W'(2);
    localparam logic [IDX_CFG_W-1:0] REG_MAX    = IDX_CFG_W'(3);

    localparam logic [CFG_W-1:0] WALL_RESET   = CFG_W'(150);
    localparam logic [CFG_W-1:0] MARGIN_RESET = CFG_W'(40);
    localparam logic [CFG_W-1:0] MIN_RESET    = CFG_W'(2);
    localparam logic [CFG_W-1:0] MAX_RESET    = CFG_W'(400);

    localparam logic CMD_ECHO  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

endpackage

`default_nettype wire

/* rtl/ultrasonic_presence_counter.sv */
// Top level of the ultrasonic presence counter: echo to distance, group
// averaging through a bit-serial divider, and person counting.
// Depends on uspc_pkg.
//
//   channel  direction  handshake                    payload
//   s        in         i_s_tvalid / o_s_tready      tdata echo_us, tuser cmd, echo_timeout
//   m        out        o_m_tvalid / i_m_tready      tdata result fields
//   cfg      in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// An echo item that does not close a group passes through the accept, multiply,
// and range check and accumulate steps. The item that closes a group then runs
// the restoring divider over all SUM_W bits of the sum when any sample was
// valid, and then decides and loads the output register. A clear command is
// taken in the idle state. A full output register stalls only the closing
// item's decide step. Reset is synchronous and active low.
`default_nettype none

module ultrasonic_presence_counter (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [uspc_pkg::ECHO_W-1:0] i_s_tdata,  // echo_us
    input  wire logic [1:0]                  i_s_tuser,  // cmd, echo_timeout
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // avg_distance_q8, valid_samples, no_valid, person_detected,
    // presence_flag, total_people
    output logic [uspc_pkg::OUT_W-1:0]       o_m_tdata,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [uspc_pkg::IDX_CFG_W-1:0] i_cfg_index,
    input  wire logic [uspc_pkg::CFG_W-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DIV,
        S_DEC
    } t_state;

    t_state r_state, n_state;

    logic [uspc_pkg::CFG_W-1:0]   r_wall, r_margin, r_min, r_max;
    logic [uspc_pkg::ECHO_W-1:0]  r_echo, n_echo;
    logic                         r_timeout, n_timeout;
    logic [uspc_pkg::DIST_W-1:0]  r_dist, n_dist;
    logic [uspc_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [uspc_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [uspc_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [uspc_pkg::CNT_W-1:0]   r_rem, n_rem;
    logic [uspc_pkg::DIVC_W-1:0]  r_divc, n_divc;
    logic [uspc_pkg::COUNT_W-1:0] r_total, n_total;
    logic                         r_present, n_present;
    logic                         r_out_valid, n_out_valid;
    logic [uspc_pkg::OUT_W-1:0]   r_out_data, n_out_data;

    logic [uspc_pkg::PROD_W-1:0]  w_prod;
    logic [uspc_pkg::DIST_W-1:0]  w_min_q8, w_max_q8;
    logic                         w_in_range;
    logic [uspc_pkg::CNT_W:0]     w_rem_sh;
    logic                         w_ge;
    logic [uspc_pkg::CFG_W-1:0]   w_trig_diff;
    logic [uspc_pkg::SUM_W-1:0]   w_trig_q8;
    logic                         w_below;
    logic                         w_s_accept;
    logic                         w_out_free;
    logic                         w_detect;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign w_s_accept = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_prod     = uspc_pkg::PROD_W'(r_echo) * uspc_pkg::PROD_W'(uspc_pkg::DIST_MUL);
    assign w_min_q8   = uspc_pkg::DIST_W'({r_min, uspc_pkg::FRAC_W'(0)});
    assign w_max_q8   = uspc_pkg::DIST_W'({r_max, uspc_pkg::FRAC_W'(0)});
    assign w_in_range = (r_dist > w_min_q8) && (r_dist < w_max_q8);

    assign w_rem_sh = {r_rem, r_sum[uspc_pkg::SUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_cnt});

    assign w_trig_diff = r_wall - r_margin;
    assign w_trig_q8   = uspc_pkg::SUM_W'({w_trig_diff, uspc_pkg::FRAC_W'(0)});
    assign w_below     = (r_wall > r_margin) && (r_sum < w_trig_q8);
    assign w_detect    = (r_cnt != '0) && w_below && !r_present;

    always_comb begin
        n_state     = r_state;
        n_echo      = r_echo;
        n_timeout   = r_timeout;
        n_dist      = r_dist;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_divc      = r_divc;
        n_total     = r_total;
        n_present   = r_present;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_s_accept) begin
                    if (i_s_tuser[0] == uspc_pkg::CMD_CLEAR) begin
                        n_total = '0;
                    end else begin
                        n_echo    = i_s_tdata;
                        n_timeout = i_s_tuser[1];
                        n_state   = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_dist  = w_prod[uspc_pkg::PROD_W-1:uspc_pkg::FRAC_W];
                n_state = S_ACC;
            end
            S_ACC: begin
                if (!r_timeout && w_in_range) begin
                    n_sum = r_sum + uspc_pkg::SUM_W'(r_dist);
                    n_cnt = r_cnt + 1'b1;
                end
                n_rem  = '0;
                n_divc = uspc_pkg::DIVC_W'(uspc_pkg::SUM_W - 1);
                if (r_idx == uspc_pkg::IDX_W'(uspc_pkg::SAMPLES_PER_GROUP - 1)) begin
                    n_idx = '0;
                    if (n_cnt != '0) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_DEC;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                n_sum = {r_sum[uspc_pkg::SUM_W-2:0], w_ge};
                if (w_ge) begin
                    n_rem = uspc_pkg::CNT_W'(w_rem_sh - {1'b0, r_cnt});
                end else begin
                    n_rem = w_rem_sh[uspc_pkg::CNT_W-1:0];
                end
                n_divc = r_divc - 1'b1;
                if (r_divc == '0) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (w_out_free) begin
                    if (r_cnt != '0) begin
                        if (w_below) begin
                            if (!r_present && (r_total != uspc_pkg::COUNT_MAX)) begin
                                n_total = r_total + 1'b1;
                            end
                            n_present = 1'b1;
                        end else begin
                            n_present = 1'b0;
                        end
                    end
                    n_out_data = {n_total, n_present, w_detect, (r_cnt == '0),
                                  r_cnt[uspc_pkg::VS_W-1:0],
                                  uspc_pkg::AVG_W'(r_sum[uspc_pkg::VDIST_W-1:0])};
                    n_out_valid = 1'b1;
                    n_sum       = '0;
                    n_cnt       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wall      <= uspc_pkg::WALL_RESET;
            r_margin    <= uspc_pkg::MARGIN_RESET;
            r_min       <= uspc_pkg::MIN_RESET;
            r_max       <= uspc_pkg::MAX_RESET;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_total     <= '0;
            r_present   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_total     <= n_total;
            r_present   <= n_present;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    uspc_pkg::REG_WALL:   r_wall   <= i_cfg_data;
                    uspc_pkg::REG_MARGIN: r_margin <= i_cfg_data;
                    uspc_pkg::REG_MIN:    r_min    <= i_cfg_data;
                    uspc_pkg::REG_MAX:    r_max    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_echo     <= n_echo;
        r_timeout  <= n_timeout;
        r_dist     <= n_dist;
        r_rem      <= n_rem;
        r_divc     <= n_divc;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire
